[design/vtd_pkg.sv]
// Shared constants and types for the vertex transform and divide core.
package vtd_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int PAIRS       = 8;
    localparam int CFG_IDX_W   = 8;
    localparam int ENT_W       = 32;
    localparam int PROD_W      = 2 * ENT_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int FRAC_W      = 16;
    localparam int ROW_W       = SUM_W - FRAC_W;
    localparam int QW          = 33;
    localparam int DIV_STEPS   = QW;
    localparam int LATENCY     = DIV_STEPS + 5;

    localparam logic OP_POINT = 1'b0;
    localparam logic OP_DIR   = 1'b1;

    localparam logic [63:0] MAG_MAX = (64'd1 << (COORD_WIDTH - 1)) - 64'd1;
    localparam logic [63:0] MAG_MIN = 64'd1 << (COORD_WIDTH - 1);
    localparam logic [31:0] VAL_MAX = MAG_MAX[31:0];
    localparam logic [63:0] NEG_MIN = 64'd0 - MAG_MIN;
    localparam logic [31:0] VAL_MIN = NEG_MIN[31:0];
    localparam logic signed [ROW_W-1:0] ROW_HI = MAG_MAX[ROW_W-1:0];
    localparam logic signed [ROW_W-1:0] ROW_LO = NEG_MIN[ROW_W-1:0];
    localparam logic [QW-1:0] Q_MAX = MAG_MAX[QW-1:0];
    localparam logic [QW-1:0] Q_MIN = MAG_MIN[QW-1:0];

    localparam logic [63:0] RST_ONE_LO = 64'h0000_0000_0001_0000;
    localparam logic [63:0] RST_ONE_HI = 64'h0001_0000_0000_0000;

    typedef struct packed {
        logic [ROW_W-1:0] rem;
        logic [QW-1:0]    num;
        logic [QW-1:0]    q;
        logic             neg;
        logic             ovf;
        logic [31:0]      pass_val;
        logic             pass_sat;
    } t_lane;

    typedef struct packed {
        t_lane [2:0]      lane;
        logic [ROW_W-1:0] den;
        logic             div;
    } t_dstage;

endpackage

[design/vertex_transform_divide_core.sv]
// Pipelined 4x4 Q16.16 point and direction transform with perspective divide by w for points.
// Registered path: capture, products, row sums, divider setup, divider steps, output register.
// Throughput: one transaction per cycle; busy never rises, the 33-stage divider sets the depth.
// Sync active-low reset clears the pipeline valids and loads the identity matrix.
// Results cannot be stalled by the receiver.
module vertex_transform_divide_core
    import vtd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic                 i_op,
    input  logic signed [31:0]   i_coord_x,
    input  logic signed [31:0]   i_coord_y,
    input  logic signed [31:0]   i_coord_z,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    output logic                 o_valid,
    output logic signed [31:0]   o_out_x,
    output logic signed [31:0]   o_out_y,
    output logic signed [31:0]   o_out_z,
    output logic                 o_divided,
    output logic                 o_saturated
);

    logic [63:0]              r_mat [PAIRS];
    logic signed [ENT_W-1:0]  m [2*PAIRS];

    logic                     r1_valid, r1_op;
    logic signed [31:0]       r1_c [3];
    logic                     r2_valid, r2_op;
    logic signed [PROD_W-1:0] r2_p [4][3];
    logic                     r3_valid, r3_op;
    logic signed [ROW_W-1:0]  r3_v [4];
    logic signed [ROW_W-1:0]  n3_v [4];
    t_dstage                  n_d0;
    t_dstage                  r_d  [DIV_STEPS+1];
    t_dstage                  n_d  [DIV_STEPS+1];
    logic                     r_dv [DIV_STEPS+1];
    logic [31:0]              n_out [3];
    logic [2:0]               n_sat;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PAIRS; i++) begin
                if (i == 0 || i == 5) begin
                    r_mat[i] <= RST_ONE_LO;
                end else if (i == 2 || i == 7) begin
                    r_mat[i] <= RST_ONE_HI;
                end else begin
                    r_mat[i] <= 64'd0;
                end
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(PAIRS))) begin
            r_mat[i_cfg_index[$clog2(PAIRS)-1:0]] <= i_cfg_data;
        end
    end

    for (genvar g = 0; g < PAIRS; g++) begin : g_ent
        assign m[2*g]   = r_mat[g][31:0];
        assign m[2*g+1] = r_mat[g][63:32];
    end

    // stage 1: capture, sign-extend from the coordinate width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_start;
        end
        r1_op   <= i_op;
        r1_c[0] <= (i_coord_x <<< (32 - COORD_WIDTH)) >>> (32 - COORD_WIDTH);
        r1_c[1] <= (i_coord_y <<< (32 - COORD_WIDTH)) >>> (32 - COORD_WIDTH);
        r1_c[2] <= (i_coord_z <<< (32 - COORD_WIDTH)) >>> (32 - COORD_WIDTH);
    end

    // stage 2: twelve exact products, row r column k
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_op <= r1_op;
        for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 3; k++) begin
                r2_p[r][k] <= m[4*k+r] * r1_c[k];
            end
        end
    end

    // stage 3: exact row sums, floored to Q34.16 by dropping fraction bits
    always_comb begin
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] t;
        for (int r = 0; r < 4; r++) begin
            t = (r2_op == OP_POINT) ? (SUM_W'(m[12+r]) <<< FRAC_W) : '0;
            s = SUM_W'(r2_p[r][0]) + SUM_W'(r2_p[r][1]) + SUM_W'(r2_p[r][2]) + t;
            n3_v[r] = s[SUM_W-1:FRAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        r3_op <= r2_op;
        r3_v  <= n3_v;
    end

    // stage 4: divider setup, overflow precheck, undivided clamp
    always_comb begin
        logic signed [ROW_W-1:0] w;
        logic signed [ROW_W-1:0] x;
        logic [ROW_W-1:0]        a;
        logic [ROW_W+FRAC_W-1:0] n;
        logic [QW-1:0]           hi;
        w         = r3_v[3];
        n_d0.div  = (r3_op == OP_POINT) && (w != '0);
        n_d0.den  = w[ROW_W-1] ? ROW_W'(-w) : ROW_W'(w);
        for (int k = 0; k < 3; k++) begin
            x  = r3_v[k];
            a  = x[ROW_W-1] ? ROW_W'(-x) : ROW_W'(x);
            n  = {a, {FRAC_W{1'b0}}};
            hi = n[ROW_W+FRAC_W-1:QW];
            n_d0.lane[k].ovf = ROW_W'(hi) >= n_d0.den;
            n_d0.lane[k].rem = ROW_W'(hi);
            n_d0.lane[k].num = n[QW-1:0];
            n_d0.lane[k].q   = '0;
            n_d0.lane[k].neg = x[ROW_W-1] ^ w[ROW_W-1];
            if (x > ROW_HI) begin
                n_d0.lane[k].pass_val = VAL_MAX;
                n_d0.lane[k].pass_sat = 1'b1;
            end else if (x < ROW_LO) begin
                n_d0.lane[k].pass_val = VAL_MIN;
                n_d0.lane[k].pass_sat = 1'b1;
            end else begin
                n_d0.lane[k].pass_val = x[31:0];
                n_d0.lane[k].pass_sat = 1'b0;
            end
        end
    end

    // restoring divider, one quotient bit per stage
    always_comb begin
        logic [ROW_W:0] t;
        logic           ge;
        n_d[0] = n_d0;
        for (int s = 1; s <= DIV_STEPS; s++) begin
            n_d[s] = r_d[s-1];
            for (int k = 0; k < 3; k++) begin
                t  = {r_d[s-1].lane[k].rem, r_d[s-1].lane[k].num[QW-1]};
                ge = t >= {1'b0, r_d[s-1].den};
                n_d[s].lane[k].rem = ge ? ROW_W'(t - {1'b0, r_d[s-1].den}) : t[ROW_W-1:0];
                n_d[s].lane[k].q   = {r_d[s-1].lane[k].q[QW-2:0], ge};
                n_d[s].lane[k].num = {r_d[s-1].lane[k].num[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DIV_STEPS; s++) begin
                r_dv[s] <= 1'b0;
            end
        end else begin
            r_dv[0] <= r3_valid;
            for (int s = 1; s <= DIV_STEPS; s++) begin
                r_dv[s] <= r_dv[s-1];
            end
        end
        for (int s = 0; s <= DIV_STEPS; s++) begin
            r_d[s] <= n_d[s];
        end
    end

    // sign and clamp of the quotient, or the clamped undivided value
    always_comb begin
        t_lane l;
        logic [QW-1:0] nq;
        for (int k = 0; k < 3; k++) begin
            l  = r_d[DIV_STEPS].lane[k];
            nq = QW'(0) - l.q;
            if (!r_d[DIV_STEPS].div) begin
                n_out[k] = l.pass_val;
                n_sat[k] = l.pass_sat;
            end else if (!l.neg) begin
                n_sat[k] = l.ovf || (l.q > Q_MAX);
                n_out[k] = n_sat[k] ? VAL_MAX : l.q[31:0];
            end else begin
                n_sat[k] = l.ovf || (l.q > Q_MIN);
                n_out[k] = n_sat[k] ? VAL_MIN : nq[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_dv[DIV_STEPS];
        end
        o_out_x     <= n_out[0];
        o_out_y     <= n_out[1];
        o_out_z     <= n_out[2];
        o_divided   <= r_d[DIV_STEPS].div;
        o_saturated <= |n_sat;
    end

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##LATENCY o_valid)
        else $error("start transaction did not produce a result on time");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_dv[0], DIV_STEPS + 1))
        else $error("result strobe without an item in the divider");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv[DIV_STEPS] && r_d[DIV_STEPS].div && r_d[DIV_STEPS].lane[0].ovf)
        |=> (o_saturated && o_divided))
        else $error("divide overflow not flagged as saturated");
`endif

endmodule

[test/tb_vertex_transform_divide_core.sv]
// Self-checking testbench for the vertex transform and divide core.
module tb_vertex_transform_divide_core;
    import vtd_pkg::*;

    localparam int ITEMS     = 850;
    localparam int CYC_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] x, y, z;
        logic        divided, saturated;
    } t_vert;

    typedef struct {
        logic        op;
        logic [31:0] x, y, z;
        logic        known;
        t_vert       res;
    } t_stim_row;

    logic              i_clk, i_rst_n, i_start, i_op, i_cfg_valid;
    logic signed [31:0] i_coord_x, i_coord_y, i_coord_z;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [63:0]       i_cfg_data;
    logic              o_busy, o_cfg_ready, o_valid, o_divided, o_saturated;
    logic signed [31:0] o_out_x, o_out_y, o_out_z;

    vertex_transform_divide_core dut (.*);

    logic [63:0] mat_regs [PAIRS];
    t_vert       pending_verts [$];
    int          err_cnt, cyc, n_sent, n_div, n_sat, n_dir;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cyc);
            $display("status: fail");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cyc);
        err_cnt++;
    endtask

    function automatic longint mat_entry(input int e);
        logic [63:0] r;
        r = mat_regs[e >> 1];
        return (e & 1) ? longint'(signed'(r[63:32])) : longint'(signed'(r[31:0]));
    endfunction

    // exact Q32.32 sum floored to Q16.16; fits in 128 bits
    function automatic longint row_sum(input int r, input longint c[3], input longint t);
        logic signed [127:0] acc;
        acc = 128'(t) <<< 16;
        for (int k = 0; k < 3; k++)
            acc += 128'(mat_entry(4 * k + r)) * 128'(c[k]);
        return longint'(acc >>> 16);
    endfunction

    function automatic longint div_by_w(input longint x, input longint w);
        logic [127:0] a, b, q;
        logic         neg;
        neg = (x < 0) != (w < 0);
        a = (x < 0) ? 128'(-x) : 128'(x);
        b = (w < 0) ? 128'(-w) : 128'(w);
        q = (a << 16) / b;
        if ((a / b) >= (128'd1 << 32)) q = 128'd1 << 48;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] clamp32(input longint v, inout logic sat);
        if (v > 64'sh7fffffff) begin sat = 1'b1; return 32'h7fffffff; end
        if (v < -64'sh80000000) begin sat = 1'b1; return 32'h80000000; end
        return v[31:0];
    endfunction

    function automatic t_vert transform_vertex(input logic op, input logic [31:0] x,
                                               input logic [31:0] y, input logic [31:0] z);
        longint c[3], v[3], w;
        t_vert  r;
        logic   sat;
        c[0] = longint'(signed'(x));
        c[1] = longint'(signed'(y));
        c[2] = longint'(signed'(z));
        r.divided = 1'b0;
        sat = 1'b0;
        if (op == OP_POINT) begin
            for (int k = 0; k < 3; k++) v[k] = row_sum(k, c, mat_entry(12 + k));
            w = row_sum(3, c, mat_entry(15));
            if (w != 0) begin
                r.divided = 1'b1;
                for (int k = 0; k < 3; k++) v[k] = div_by_w(v[k], w);
            end
        end else begin
            for (int k = 0; k < 3; k++) v[k] = row_sum(k, c, 0);
        end
        r.x = clamp32(v[0], sat);
        r.y = clamp32(v[1], sat);
        r.z = clamp32(v[2], sat);
        r.saturated = sat;
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_vert want;
        if (i_rst_n && o_valid) begin
            if (pending_verts.size() == 0) begin
                $display("unexpected result at cycle %0d", cyc);
                err_cnt++;
            end else begin
                want = pending_verts.pop_front();
                if (o_out_x !== want.x) report("out_x", o_out_x, want.x);
                if (o_out_y !== want.y) report("out_y", o_out_y, want.y);
                if (o_out_z !== want.z) report("out_z", o_out_z, want.z);
                if (o_divided !== want.divided) report("divided", o_divided, want.divided);
                if (o_saturated !== want.saturated)
                    report("saturated", o_saturated, want.saturated);
                if (want.divided) n_div++;
                if (want.saturated) n_sat++;
            end
        end
    end

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic write_matrix(input int idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx[CFG_IDX_W-1:0];
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx < PAIRS) mat_regs[idx] = val;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_verts.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // hold start high across back-to-back transactions when gap is zero
    task automatic send_vertex(input logic op, input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic known, input t_vert res,
                               input logic gaps);
        t_vert want;
        want = transform_vertex(op, x, y, z);
        if (known && want != res) begin
            $display("table row disagrees with predictor for op %0d", op);
            err_cnt++;
        end
        i_start   <= 1'b1;
        i_op      <= op;
        i_coord_x <= x;
        i_coord_y <= y;
        i_coord_z <= z;
        do @(posedge i_clk); while (o_busy);
        pending_verts.push_back(want);
        n_sent++;
        if (op == OP_DIR) n_dir++;
        if (gaps && $urandom_range(0, 2) == 0) begin
            i_start <= 1'b0;
            @(posedge i_clk);
            idle_gap();
        end
    endtask

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 32'h3ffff) - 32'h20000;
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
            default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    function automatic logic [63:0] rand_pair(input int mode);
        logic [31:0] lo, hi;
        lo = rand_coord(mode == 0 ? 1 : $urandom_range(0, 3));
        hi = rand_coord(mode == 0 ? 1 : $urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0) lo = 32'h0;
        return {hi, lo};
    endfunction

    t_stim_row dir_rows [$];

    initial begin
        t_vert none;
        int    mode;
        none = '{default: '0};
        err_cnt = 0; cyc = 0; n_sent = 0; n_div = 0; n_sat = 0; n_dir = 0;
        i_rst_n = 1'b0; i_start = 1'b0; i_op = OP_POINT;
        i_coord_x = '0; i_coord_y = '0; i_coord_z = '0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        mat_regs[0] = RST_ONE_LO; mat_regs[1] = '0; mat_regs[2] = RST_ONE_HI;
        mat_regs[3] = '0; mat_regs[4] = '0; mat_regs[5] = RST_ONE_LO;
        mat_regs[6] = '0; mat_regs[7] = RST_ONE_HI;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity after reset: w is one, so points pass through divided and directions undivided
        dir_rows = '{
            '{OP_POINT, 32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 1'b1,
              '{32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 1'b1, 1'b0}},
            '{OP_POINT, 32'h7fffffff, 32'h80000000, 32'h0, 1'b1,
              '{32'h7fffffff, 32'h80000000, 32'h0, 1'b1, 1'b0}},
            '{OP_DIR, 32'h7fffffff, 32'h80000000, 32'hffffffff, 1'b1,
              '{32'h7fffffff, 32'h80000000, 32'hffffffff, 1'b0, 1'b0}},
            '{OP_DIR, 32'h0, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 32'h0, 1'b0, 1'b0}},
            '{OP_POINT, 32'h0000_0001, 32'hffff_ffff, 32'h1234_5678, 1'b0, none}
        };
        foreach (dir_rows[i])
            send_vertex(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                        dir_rows[i].known, dir_rows[i].res, 1'b1);
        i_start <= 1'b0;
        wait_drained();

        // zero w row: point mode passes undivided sums; large negative w; overflow
        for (int k = 0; k < PAIRS; k++) write_matrix(k, '0);
        write_matrix(0, 64'h0000_0000_7fff_ffff);
        write_matrix(5, 64'h0000_0000_7fff_ffff);
        write_matrix(PAIRS + 3, 64'hdead_beef_dead_beef);
        dir_rows = '{
            '{OP_POINT, 32'h0, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 32'h0, 1'b0, 1'b0}},
            '{OP_POINT, 32'h7fffffff, 32'h0, 32'h0, 1'b0, none},
            '{OP_DIR, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b0, none}
        };
        foreach (dir_rows[i])
            send_vertex(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                        dir_rows[i].known, dir_rows[i].res, 1'b1);
        i_start <= 1'b0;
        wait_drained();
        write_matrix(3, 64'hffff_ffff_0000_0000);  // w row gets -1 ulp * y
        write_matrix(7, 64'h8000_0000_0000_0000);
        for (int i = 0; i < 12; i++)
            send_vertex(i[0], rand_coord(i % 4), rand_coord(2), rand_coord(3), 1'b0, none,
                        1'b1);
        i_start <= 1'b0;
        wait_drained();

        // random phases, each with a fresh matrix
        while (n_sent < ITEMS) begin
            mode = $urandom_range(0, 3);
            for (int k = 0; k < PAIRS; k++) write_matrix(k, rand_pair(mode));
            if ($urandom_range(0, 2) == 0) write_matrix(3, {32'h0, 32'h0});
            repeat ($urandom_range(40, 120)) begin
                logic g;
                if (n_sent >= ITEMS) break;
                g = ($urandom_range(0, 3) != 0);
                send_vertex($urandom_range(0, 3) == 0 ? OP_DIR : OP_POINT,
                            rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)),
                            rand_coord($urandom_range(0, 3)), 1'b0, none, g);
            end
            i_start <= 1'b0;
            wait_drained();
        end

        $display("sent %0d vertices (%0d direction), %0d divided, %0d saturated",
                 n_sent, n_dir, n_div, n_sat);
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
